// ----- src/sil_pkg.sv -----
// shared constants and types for the symbol interval lookup block
// no dependencies; used by the interfaces, the comparator and the top level
package sil_pkg;

  localparam int ADDR_W       = 32;
  localparam int LEN_W        = 32;
  localparam int ENTRY_IDX_W  = 10;
  localparam int COUNT_W      = 11;
  localparam int MODE_W       = 2;
  localparam int SYM_IDX_W    = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // search modes
  localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BWD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLED  = 2'd1;

  // where the query sits relative to one table entry
  typedef struct packed {
    logic below;   // query < start
    logic beyond;  // query >= start + length
  } cmp_res_t;

endpackage

// ----- src/sil_in_if.sv -----
// input channel: load and lookup requests with valid/ready handshake
// depends on sil_pkg
interface sil_in_if import sil_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [ADDR_W-1:0]      entry_start;
  logic [LEN_W-1:0]       entry_length;
  logic [ADDR_W-1:0]      query_addr;
  logic [MODE_W-1:0]      search_mode;

  modport source (output valid, req_type, entry_index, entry_start, entry_length,
                  query_addr, search_mode, input ready);
  modport sink   (input valid, req_type, entry_index, entry_start, entry_length,
                  query_addr, search_mode, output ready);
endinterface

// ----- src/sil_out_if.sv -----
// result channel: lookup outcome with valid/ready handshake
// depends on sil_pkg
interface sil_out_if import sil_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [SYM_IDX_W-1:0] symbol_index;

  modport source (output valid, found, symbol_index, input ready);
  modport sink   (input valid, found, symbol_index, output ready);
endinterface

// ----- src/sil_cfg_if.sv -----
// configuration write channel: register index and data with valid/ready
// depends on sil_pkg
interface sil_cfg_if import sil_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/sil_cmp.sv -----
// interval compare unit shared by all search modes
// depends on sil_pkg; end address formed at 33 bits so it never wraps
module sil_cmp import sil_pkg::*; (
  input  logic [ADDR_W-1:0] query,
  input  logic [ADDR_W-1:0] start,
  input  logic [LEN_W-1:0]  length,
  output cmp_res_t          res
);

  logic [ADDR_W:0] end_addr;

  assign end_addr   = {1'b0, start} + (ADDR_W+1)'(length);
  assign res.below  = query < start;
  assign res.beyond = {1'b0, query} >= end_addr;

endmodule

// ----- src/symbol_interval_lookup_core.sv -----
// symbol interval table with forward, backward and binary address lookup
// load: no result. lookup that cannot search (map off, count 0, bad mode):
// result registered at the accept edge. forward/backward: one entry per cycle through the
// single table read port. binary: each probe is a read state, then a compare state.
// no new load or lookup during a search. reset (rst_n low, synchronous) clears the config
// registers, the output valid and the sequencer; the table is not cleared
module symbol_interval_lookup_core import sil_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  sil_in_if.sink    in_ch,
  sil_out_if.source out_ch,
  sil_cfg_if.sink   cfg_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int EW = ADDR_W + LEN_W;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_LIN     = 4'b0010,
    ST_BIN_RD  = 4'b0100,
    ST_BIN_CHK = 4'b1000
  } state_t;

  state_t st_r, st_nxt;

  logic [CW-1:0]        sym_n_r;
  logic                 map_en_r;
  logic [ADDR_W-1:0]    qaddr_r, qaddr_nxt;
  logic                 bwd_r, bwd_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hx_r, hx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]        rd_idx_r;
  logic [EW-1:0]        rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        mid;
  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r, found_nxt;
  logic [SYM_IDX_W-1:0] sidx_r, sidx_nxt;
  logic                 res_we;
  logic                 in_acc, out_acc, cfg_acc;
  logic                 load_we;
  logic [NW-1:0]        cnt_ext;
  cmp_res_t             cmp;
  logic                 hit;

  logic [EW-1:0] tbl_mem [TABLE_DEPTH];

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  // output slot is free or draining at accept, so a finished search never waits
  assign in_ch.ready  = (st_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.symbol_index = sidx_r;

  // configuration registers, count clamped to the table depth on write
  assign cnt_ext = NW'(cfg_ch.data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_n_r  <= '0;
      map_en_r <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_ch.addr)
        CFG_SYMBOL_COUNT: begin
          sym_n_r <= (cnt_ext > NW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);
        end
        CFG_MAP_ENABLED: begin
          map_en_r <= cfg_ch.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // table memory: one write port for loads, one registered read port for searches
  assign load_we = in_acc && (in_ch.req_type == REQ_LOAD) &&
                   (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (load_we) begin
      tbl_mem[AW'(in_ch.entry_index)] <= {in_ch.entry_start, in_ch.entry_length};
    end
  end

  assign mid     = lo_r + ((hx_r - lo_r - CW'(1)) >> 1);
  assign rd_addr = (st_r == ST_BIN_RD) ? AW'(mid) : AW'(iss_r);

  always_ff @(posedge clk) begin
    rd_data_r <= tbl_mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  sil_cmp u_cmp (
    .query  (qaddr_r),
    .start  (rd_data_r[EW-1:LEN_W]),
    .length (rd_data_r[LEN_W-1:0]),
    .res    (cmp)
  );

  assign hit = !cmp.below && !cmp.beyond;

  // search sequencer
  always_comb begin
    st_nxt     = st_r;
    qaddr_nxt  = qaddr_r;
    bwd_nxt    = bwd_r;
    iss_nxt    = iss_r;
    rem_nxt    = rem_r;
    lo_nxt     = lo_r;
    hx_nxt     = hx_r;
    rd_vld_nxt = 1'b0;
    res_we     = 1'b0;
    found_nxt  = found_r;
    sidx_nxt   = sidx_r;

    case (st_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.req_type == REQ_LOOKUP)) begin
          qaddr_nxt = in_ch.query_addr;
          bwd_nxt   = (in_ch.search_mode == MODE_BWD);
          if (!map_en_r || (sym_n_r == '0) ||
              !(in_ch.search_mode inside {MODE_FWD, MODE_BWD, MODE_BIN})) begin
            res_we    = 1'b1;
            found_nxt = 1'b0;
            sidx_nxt  = '0;
          end else if (in_ch.search_mode == MODE_BIN) begin
            lo_nxt = '0;
            hx_nxt = sym_n_r;
            st_nxt = ST_BIN_RD;
          end else begin
            iss_nxt = (in_ch.search_mode == MODE_BWD) ? (sym_n_r - CW'(1)) : '0;
            rem_nxt = sym_n_r;
            st_nxt  = ST_LIN;
          end
        end
      end

      ST_LIN: begin
        // issue one read per cycle while checking the previous one
        if (rem_r != '0) begin
          rd_vld_nxt = 1'b1;
          iss_nxt    = bwd_r ? (iss_r - CW'(1)) : (iss_r + CW'(1));
          rem_nxt    = rem_r - CW'(1);
        end
        if (rd_vld_r && hit) begin
          res_we     = 1'b1;
          found_nxt  = 1'b1;
          sidx_nxt   = SYM_IDX_W'(rd_idx_r);
          rd_vld_nxt = 1'b0;
          st_nxt     = ST_IDLE;
        end else if (!rd_vld_r && (rem_r == '0)) begin
          res_we    = 1'b1;
          found_nxt = 1'b0;
          sidx_nxt  = '0;
          st_nxt    = ST_IDLE;
        end
      end

      ST_BIN_RD: begin
        if (lo_r < hx_r) begin
          st_nxt = ST_BIN_CHK;
        end else begin
          res_we    = 1'b1;
          found_nxt = 1'b0;
          sidx_nxt  = '0;
          st_nxt    = ST_IDLE;
        end
      end

      ST_BIN_CHK: begin
        if (hit) begin
          res_we    = 1'b1;
          found_nxt = 1'b1;
          sidx_nxt  = SYM_IDX_W'(rd_idx_r);
          st_nxt    = ST_IDLE;
        end else begin
          if (cmp.below) begin
            hx_nxt = CW'(rd_idx_r);
          end else begin
            lo_nxt = CW'(rd_idx_r) + CW'(1);
          end
          st_nxt = ST_BIN_RD;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = res_we || (out_valid_r && !out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qaddr_r <= qaddr_nxt;
    bwd_r   <= bwd_nxt;
    iss_r   <= iss_nxt;
    rem_r   <= rem_nxt;
    lo_r    <= lo_nxt;
    hx_r    <= hx_nxt;
    found_r <= found_nxt;
    sidx_r  <= sidx_nxt;
  end

`ifndef SYNTH
  a_miss_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.symbol_index == '0)
    else $error("miss result carries nonzero index");

  a_disabled_miss: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.req_type == REQ_LOOKUP) && !map_en_r |=> out_ch.valid && !out_ch.found)
    else $error("lookup on disabled map did not miss at once");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.req_type == REQ_LOAD) |=> st_r == ST_IDLE && !out_ch.valid ||
      st_r == ST_IDLE && $past(out_valid_r))
    else $error("load started a search or produced a result");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LIN |-> rem_r <= sym_n_r)
    else $error("scan issued more entries than the count");

  a_bin_window: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_BIN_CHK |-> lo_r <= CW'(rd_idx_r) && CW'(rd_idx_r) < hx_r)
    else $error("binary probe outside the search window");
`endif

endmodule
